// ----- design/chs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_pkg
// shared types and constants of the chained hash set unit
// ----------------------------------------------------------------------------
package chs_pkg;

    localparam int MAX_BUCKETS_DEF      = 128;
    localparam int SLOTS_PER_BUCKET_DEF = 8;

    localparam int KEY_W   = 31;
    localparam int FUNC_W  = 2;
    localparam int COLL_W  = 10;
    localparam int LOAD_W  = 4;
    localparam int BCNT_W  = 8;
    localparam int REM_W   = BCNT_W + 1;
    localparam int OUT_W   = 16;
    localparam int IN_W    = 32;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    localparam logic [BCNT_W-1:0] BCNT_RESET = 8'd7;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DIV  = 8'b0000_0010,
        ST_FRD  = 8'b0000_0100,
        ST_FILL = 8'b0000_1000,
        ST_RD   = 8'b0001_0000,
        ST_CMP  = 8'b0010_0000,
        ST_UPD  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

endpackage

// ----- design/chs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_ram
// generic simple dual-port ram, one write port, registered read port
// ----------------------------------------------------------------------------
module chs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/chained_hash_set_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_set_unit
// hash set with separate chaining, bucket = key mod bucket_count (0 taken as 1,
//   above MAX_BUCKETS taken as MAX_BUCKETS); steps: bit-serial remainder, then
//   the fill read (insert writes in the fill state), search/remove read and
//   compare each stored slot of the chain, then update and report; report waits while a prior result is not taken
// requests: one at a time, a new one is taken only in idle
// reset: fill valid bits, histogram and counters clear at once, no sweep
// ----------------------------------------------------------------------------
module chained_hash_set_unit
    import chs_pkg::*;
#(
    parameter int MAX_BUCKETS      = MAX_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // key[30:0], zero[31]
    input  logic [FUNC_W-1:0] s_tuser,   // func[1:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata    // found[0], bucket_full[1],
                                         // collisions[11:2], max_bucket_load[15:12]
);

    localparam int BW    = $clog2(MAX_BUCKETS);
    localparam int FW    = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int DEPTH = MAX_BUCKETS * SLOTS_PER_BUCKET;
    localparam int AW    = $clog2(DEPTH);
    localparam int TOT_W = $clog2(DEPTH + 1);
    localparam int NE_W  = $clog2(MAX_BUCKETS + 1);

    state_t state_reg, state_next;

    logic [BCNT_W-1:0] bcnt_reg;
    logic [FUNC_W-1:0] func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [4:0]        bit_reg;
    logic [FW-1:0]     fill_reg;
    logic [FW-1:0]     idx_reg;
    logic [FW-1:0]     wr_reg;
    logic              found_reg;
    logic              full_reg;

    logic [NE_W-1:0]   hist_reg [SLOTS_PER_BUCKET];
    logic [TOT_W-1:0]  total_reg;
    logic [NE_W-1:0]   ne_reg;
    logic              valid_reg [MAX_BUCKETS];

    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    // remainder step
    logic [REM_W-1:0]  ncount;
    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  rem_step;

    always_comb
    begin
        if (bcnt_reg == '0)
            ncount = REM_W'(1);
        else if (int'(bcnt_reg) > MAX_BUCKETS)
            ncount = REM_W'(MAX_BUCKETS);
        else
            ncount = {1'b0, bcnt_reg};
        rem_shift = {rem_reg[REM_W-2:0], key_reg[bit_reg]};
        rem_step  = (rem_shift >= ncount) ? rem_shift - ncount : rem_shift;
    end

    logic [BW-1:0] bucket;
    assign bucket = BW'(rem_reg);

    // memories
    logic          kram_we;
    logic [AW-1:0] kram_waddr;
    logic [AW-1:0] kram_raddr;
    logic [KEY_W-1:0] kram_wdata;
    logic [KEY_W-1:0] kram_rdata;
    logic          fram_we;
    logic [FW-1:0] fram_wdata;
    logic [FW-1:0] fram_rdata;
    logic [AW-1:0] base_addr;

    assign base_addr  = AW'(bucket) * AW'(SLOTS_PER_BUCKET);
    assign kram_raddr = base_addr + AW'(idx_reg);

    chs_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (kram_we),
        .waddr (kram_waddr),
        .wdata (kram_wdata),
        .raddr (kram_raddr),
        .rdata (kram_rdata)
    );

    chs_ram #(.WIDTH(FW), .DEPTH(MAX_BUCKETS)) u_fill_ram (
        .clk   (clk),
        .we    (fram_we),
        .waddr (bucket),
        .wdata (fram_wdata),
        .raddr (bucket),
        .rdata (fram_rdata)
    );

    logic [FW-1:0] fill_now;
    logic          key_match;
    assign fill_now  = valid_reg[bucket] ? fram_rdata : '0;
    assign key_match = (kram_rdata == key_reg);

    // statistics update and ram write control
    logic          st_en;
    logic [FW-1:0] old_load;
    logic [FW-1:0] new_load;

    always_comb
    begin
        st_en      = 1'b0;
        old_load   = fill_now;
        new_load   = fill_now + FW'(1);
        kram_we    = 1'b0;
        kram_waddr = base_addr + AW'(wr_reg);
        kram_wdata = kram_rdata;
        fram_we    = 1'b0;
        fram_wdata = wr_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (func_reg == FUNC_INSERT && fill_now != FW'(SLOTS_PER_BUCKET))
                begin
                    st_en      = 1'b1;
                    kram_we    = 1'b1;
                    kram_waddr = base_addr + AW'(fill_now);
                    kram_wdata = key_reg;
                    fram_we    = 1'b1;
                    fram_wdata = fill_now + FW'(1);
                end
            end
            ST_CMP:
            begin
                kram_we = (func_reg == FUNC_REMOVE) && !key_match;
            end
            ST_UPD:
            begin
                old_load = fill_reg;
                new_load = wr_reg;
                if (func_reg == FUNC_REMOVE && wr_reg != fill_reg)
                begin
                    st_en   = 1'b1;
                    fram_we = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // reported statistics
    logic [COLL_W-1:0] coll_now;
    logic [LOAD_W-1:0] maxl_now;

    always_comb
    begin
        coll_now = COLL_W'(total_reg - TOT_W'(ne_reg));
        maxl_now = '0;
        for (int k = 0; k < SLOTS_PER_BUCKET; k++)
        begin
            if (hist_reg[k] != '0)
                maxl_now = LOAD_W'(k + 1);
        end
    end

    // control
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_DIV;
            ST_DIV:  if (bit_reg == '0) state_next = ST_FRD;
            ST_FRD:  state_next = ST_FILL;
            ST_FILL:
            begin
                if ((func_reg == FUNC_SEARCH || func_reg == FUNC_REMOVE) && fill_now != '0)
                    state_next = ST_RD;
                else
                    state_next = ST_UPD;
            end
            ST_RD:   state_next = ST_CMP;
            ST_CMP:  state_next = (idx_reg + FW'(1) < fill_reg) ? ST_RD : ST_UPD;
            ST_UPD:  state_next = ST_DONE;
            ST_DONE: if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            bcnt_reg     <= BCNT_RESET;
            total_reg    <= '0;
            ne_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < SLOTS_PER_BUCKET; k++)
                hist_reg[k] <= '0;
            for (int b = 0; b < MAX_BUCKETS; b++)
                valid_reg[b] <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (psel && penable && pwrite && !paddr[2])
                bcnt_reg <= pwdata[BCNT_W-1:0];
            if (fram_we)
                valid_reg[bucket] <= 1'b1;
            if (st_en)
            begin
                total_reg <= total_reg + TOT_W'(new_load) - TOT_W'(old_load);
                for (int k = 0; k < SLOTS_PER_BUCKET; k++)
                begin
                    hist_reg[k] <= hist_reg[k]
                        + NE_W'(int'(new_load) == k + 1)
                        - NE_W'(int'(old_load) == k + 1);
                end
                if (old_load == '0 && new_load != '0)
                    ne_reg <= ne_reg + NE_W'(1);
                else if (old_load != '0 && new_load == '0)
                    ne_reg <= ne_reg - NE_W'(1);
            end
            if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready))
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                func_reg  <= s_tuser;
                key_reg   <= s_tdata[KEY_W-1:0];
                rem_reg   <= '0;
                bit_reg   <= 5'(KEY_W - 1);
                found_reg <= 1'b0;
                full_reg  <= 1'b0;
            end
            ST_DIV:
            begin
                rem_reg <= rem_step;
                bit_reg <= bit_reg - 5'd1;
            end
            ST_FILL:
            begin
                fill_reg <= fill_now;
                idx_reg  <= '0;
                wr_reg   <= '0;
                full_reg <= (func_reg == FUNC_INSERT) && (fill_now == FW'(SLOTS_PER_BUCKET));
            end
            ST_CMP:
            begin
                idx_reg <= idx_reg + FW'(1);
                if (key_match)
                    found_reg <= 1'b1;
                else
                    wr_reg <= wr_reg + FW'(1);
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                    m_tdata_reg <= {maxl_now, coll_now, full_reg, found_reg};
            end
            default:
            begin
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? 32'd0 : {24'd0, bcnt_reg};

endmodule
